### hdl/rmth_pkg.sv
package rmth_pkg;

    localparam int CAPACITY_DEF    = 256;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MEDIAN_BITS     = 17;
    localparam int COUNT_BITS      = 9;

    typedef enum logic {
        HOP_PUSH,
        HOP_REPLACE
    } t_heap_op;

    typedef struct packed {
        logic     start;
        t_heap_op op;
    } t_heap_ctl;

    typedef enum logic [2:0] {
        HS_IDLE,
        HS_UP_RD,
        HS_UP_CMP,
        HS_DN_RD1,
        HS_DN_RD2,
        HS_DN_CMP
    } t_heap_state;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_OUT
    } t_top_state;

endpackage

### hdl/rmth_in_if.sv
interface rmth_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

### hdl/rmth_out_if.sv
interface rmth_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] median_twice;
    logic [8:0]  held_count;
    logic        rejected;

    modport source (output valid, output median_twice, output held_count, output rejected,
                    input ready);
    modport sink   (input valid, input median_twice, input held_count, input rejected,
                    output ready);
endinterface

### hdl/rmth_ram.sv
module rmth_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/rmth_heap.sv
module rmth_heap
    import rmth_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_heap_ctl        i_ctl,
    input  logic [WIDTH-1:0] i_value,
    input  logic [CW-1:0]    i_size,
    output logic             o_busy,
    output logic [WIDTH-1:0] o_top
);

    // Max-heap in one RAM; the top entry is mirrored in a register.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = CW + 1;

    t_heap_state      r_state, n_state;
    logic [AW-1:0]    r_idx, n_idx;
    logic [WIDTH-1:0] r_val, n_val;
    logic [CW-1:0]    r_size, n_size;
    logic [WIDTH-1:0] r_c1, n_c1;
    logic             r_two, n_two;
    logic [WIDTH-1:0] r_top;

    logic             we;
    logic [AW-1:0]    waddr, raddr, parent, bidx;
    logic [WIDTH-1:0] wdata, rdata, bval;
    logic [XW-1:0]    c1x, c2x, sizex;
    logic             take_c2, up_move, dn_move, c1_out;

    rmth_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign c1x     = XW'({r_idx, 1'b1});
    assign c2x     = c1x + XW'(1);
    assign sizex   = XW'(r_size);
    assign parent  = AW'(r_idx - AW'(1)) >> 1;
    assign take_c2 = r_two && ($signed(rdata) > $signed(r_c1));
    assign bval    = take_c2 ? rdata : r_c1;
    assign bidx    = take_c2 ? c2x[AW-1:0] : c1x[AW-1:0];
    assign up_move = $signed(rdata) < $signed(r_val);
    assign dn_move = $signed(bval) > $signed(r_val);
    assign c1_out  = c1x >= sizex;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            HS_IDLE: begin
                if (i_ctl.start) begin
                    n_state = (i_ctl.op == HOP_PUSH) ? HS_UP_RD : HS_DN_RD1;
                end
            end
            HS_UP_RD:  n_state = (r_idx == '0) ? HS_IDLE : HS_UP_CMP;
            HS_UP_CMP: n_state = up_move ? HS_UP_RD : HS_IDLE;
            HS_DN_RD1: n_state = c1_out ? HS_IDLE : HS_DN_RD2;
            HS_DN_RD2: n_state = HS_DN_CMP;
            HS_DN_CMP: n_state = dn_move ? HS_DN_RD1 : HS_IDLE;
            default:   n_state = HS_IDLE;
        endcase
    end

    always_comb begin
        n_idx  = r_idx;
        n_val  = r_val;
        n_size = r_size;
        n_c1   = r_c1;
        n_two  = r_two;
        we     = 1'b0;
        waddr  = r_idx;
        wdata  = r_val;
        raddr  = parent;
        unique case (r_state)
            HS_IDLE: begin
                if (i_ctl.start) begin
                    n_val  = i_value;
                    n_size = i_size;
                    n_idx  = (i_ctl.op == HOP_PUSH) ? AW'(i_size) : '0;
                end
            end
            HS_UP_RD: begin
                if (r_idx == '0) begin
                    we = 1'b1;
                end
            end
            HS_UP_CMP: begin
                we = 1'b1;
                if (up_move) begin
                    wdata = rdata;
                    n_idx = parent;
                end
            end
            HS_DN_RD1: begin
                raddr = c1x[AW-1:0];
                if (c1_out) begin
                    we = 1'b1;
                end
            end
            HS_DN_RD2: begin
                n_c1  = rdata;
                n_two = c2x < sizex;
                raddr = c2x[AW-1:0];
            end
            HS_DN_CMP: begin
                we = 1'b1;
                if (dn_move) begin
                    wdata = bval;
                    n_idx = bidx;
                end
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= HS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_idx  <= n_idx;
        r_val  <= n_val;
        r_size <= n_size;
        r_c1   <= n_c1;
        r_two  <= n_two;
        if (we && waddr == '0) begin
            r_top <= wdata;
        end
    end

    assign o_busy = (r_state != HS_IDLE);
    assign o_top  = r_top;

endmodule

### hdl/running_median_two_heaps_top.sv
// A rejected sample goes straight from idle to the output state; any other sample
// waits in the wait state for the heap sift. Both halves sift in parallel in their own
// RAMs, so the slower sift sets the time per sample. One sample is worked on at a time;
// a new one is taken while the previous result waits.
// Reset (synchronous, active low) empties both halves at once; no clearing pass.
module running_median_two_heaps_top
    import rmth_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rmth_in_if.sink    i_in,
    rmth_out_if.source o_out
);

    localparam int LDEPTH = (CAPACITY + 1) / 2;
    localparam int UDEPTH = CAPACITY / 2;
    localparam int LCW    = $clog2(LDEPTH + 1);
    localparam int UCW    = $clog2(UDEPTH + 1);
    localparam int TW     = $clog2(CAPACITY + 1);
    localparam int SB     = SAMPLE_BITS;

    t_top_state r_state, n_state;
    logic [LCW-1:0] r_nl, n_nl;
    logic [UCW-1:0] r_nu, n_nu;
    logic           r_rej;
    logic           r_ovalid;
    logic [MEDIAN_BITS-1:0] r_omed;
    logic [COUNT_BITS-1:0]  r_ocnt;
    logic                   r_orej;

    t_heap_ctl   l_ctl, u_ctl;
    logic [SB-1:0] l_val, u_val, l_top, u_top, s, lmax, umin;
    logic        l_busy, u_busy;
    logic        acc, full, eq, load;
    logic [TW-1:0] total;
    logic signed [SB:0]    msum;
    logic [SB+16:0]        mext;
    logic [TW+8:0]         cext;

    // The upper half is kept inverted so that both halves are max-heaps.
    rmth_heap #(.WIDTH(SB), .DEPTH(LDEPTH)) u_lower (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (l_ctl),
        .i_value (l_val),
        .i_size  (r_nl),
        .o_busy  (l_busy),
        .o_top   (l_top)
    );

    rmth_heap #(.WIDTH(SB), .DEPTH(UDEPTH)) u_upper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (u_ctl),
        .i_value (u_val),
        .i_size  (r_nu),
        .o_busy  (u_busy),
        .o_top   (u_top)
    );

    assign s     = i_in.sample;
    assign lmax  = l_top;
    assign umin  = ~u_top;
    assign total = TW'(r_nl) + TW'(r_nu);
    assign full  = total >= TW'(CAPACITY);
    assign eq    = TW'(r_nl) == TW'(r_nu);
    assign acc   = i_in.valid && (r_state == ST_IDLE);
    assign load  = (r_state == ST_OUT) && (!r_ovalid || o_out.ready);

    assign i_in.ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_state = full ? ST_OUT : ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!l_busy && !u_busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        l_ctl = '{start: 1'b0, op: HOP_PUSH};
        u_ctl = '{start: 1'b0, op: HOP_PUSH};
        l_val = s;
        u_val = ~s;
        n_nl  = r_nl;
        n_nu  = r_nu;
        if (acc && !full) begin
            priority if (r_nl == '0) begin
                l_ctl.start = 1'b1;
                n_nl        = r_nl + LCW'(1);
            end else if ($signed(s) < $signed(lmax)) begin
                l_ctl.start = 1'b1;
                if (eq) begin
                    n_nl = r_nl + LCW'(1);
                end else begin
                    // The old lower maximum moves across to the upper half.
                    l_ctl.op    = HOP_REPLACE;
                    u_ctl.start = 1'b1;
                    u_val       = ~lmax;
                    n_nu        = r_nu + UCW'(1);
                end
            end else if (!eq) begin
                u_ctl.start = 1'b1;
                n_nu        = r_nu + UCW'(1);
            end else if (r_nu == '0 || $signed(s) <= $signed(umin)) begin
                l_ctl.start = 1'b1;
                n_nl        = r_nl + LCW'(1);
            end else begin
                // The upper minimum moves down and the sample takes its place.
                u_ctl.start = 1'b1;
                u_ctl.op    = HOP_REPLACE;
                l_ctl.start = 1'b1;
                l_val       = umin;
                n_nl        = r_nl + LCW'(1);
            end
        end
    end

    always_comb begin
        if (r_nl == '0) begin
            msum = '0;
        end else if (eq) begin
            msum = $signed({lmax[SB-1], lmax}) + $signed({umin[SB-1], umin});
        end else begin
            msum = $signed({lmax[SB-1], lmax}) + $signed({lmax[SB-1], lmax});
        end
        mext = {{16{msum[SB]}}, msum};
        cext = {9'b0, total};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_nl     <= '0;
            r_nu     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_nl    <= n_nl;
            r_nu    <= n_nu;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (acc) begin
            r_rej <= full;
        end
        if (load) begin
            r_omed <= mext[MEDIAN_BITS-1:0];
            r_ocnt <= cext[COUNT_BITS-1:0];
            r_orej <= r_rej;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.median_twice = r_omed;
    assign o_out.held_count   = r_ocnt;
    assign o_out.rejected     = r_orej;

endmodule

### hdl/rmth_checker.sv
module rmth_checker
    import rmth_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [16:0] i_out_median,
    input logic [8:0]  i_out_count,
    input logic        i_out_rejected
);

    localparam logic [COUNT_BITS-1:0] CAP_COUNT = COUNT_BITS'(CAPACITY);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_median) && $stable(i_out_count) && $stable(i_out_rejected))
        else $error("result changed while stalled");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_rejected |-> i_out_count == CAP_COUNT)
        else $error("sample rejected below capacity");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && CAPACITY < 512 |-> i_out_count != '0)
        else $error("result with empty store");

    a_reject_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_rejected ##1 i_out_valid
            |-> i_out_rejected)
        else $error("store full then accepted a sample");

endmodule

bind running_median_two_heaps_top rmth_checker #(.CAPACITY(CAPACITY)) u_rmth_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_median   (o_out.median_twice),
    .i_out_count    (o_out.held_count),
    .i_out_rejected (o_out.rejected)
);
